@@ rtl/osm_pkg.sv @@
`timescale 1ns / 1ps

package osm_pkg;

  // Field widths fixed by the item format.
  localparam int KEY_W     = 16;
  localparam int CNT_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // Default geometry of the modifier code ranges.
  localparam int NUM_MODS_DEF = 8;
  localparam int OSM_BASE_DEF = 49152;
  localparam int MOD_BASE_DEF = 224;

  // Reset values of the configuration registers.
  localparam logic             ENABLE_RESET  = 1'b1;
  localparam logic             AUTO_RESET    = 1'b0;
  localparam logic [CNT_W-1:0] TIMEOUT_RESET = 16'd40;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;

  // Input item kinds.
  localparam logic MODE_KEY  = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // Controller to datapath.
  typedef struct packed {
    logic latch;    // capture the incoming item
    logic exec;     // apply the item to the state, load the first result
    logic emit;     // load an injected press for the current scan slot
    logic advance;  // move the scan slot on by one
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic inject;   // the captured tick injects presses
    logic bit_set;  // the current scan slot holds a press to inject
    logic last;     // the result register holds the final result of the item
  } status_t;

endpackage

@@ rtl/osm_in_if.sv @@
`timescale 1ns / 1ps

interface osm_in_if;
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [osm_pkg::KEY_W-1:0] key_code;
  logic                     key_down;
  logic                     was_pressed;
  logic                     injected;

  modport source(output valid, mode, key_code, key_down, was_pressed, injected,
                 input ready);
  modport sink(input valid, mode, key_code, key_down, was_pressed, injected,
               output ready);
endinterface

@@ rtl/osm_out_if.sv @@
`timescale 1ns / 1ps

interface osm_out_if;
  logic                     valid;
  logic                     ready;
  logic [osm_pkg::KEY_W-1:0] out_key;
  logic                     injected_press;
  logic                     active;
  logic                     last;

  modport source(output valid, out_key, injected_press, active, last, input ready);
  modport sink(input valid, out_key, injected_press, active, last, output ready);
endinterface

@@ rtl/osm_cfg_if.sv @@
`timescale 1ns / 1ps

interface osm_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [osm_pkg::CFG_IDX_W-1:0] index;
  logic [osm_pkg::CFG_DAT_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/osm_ctrl.sv @@
`timescale 1ns / 1ps

module osm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  osm_pkg::status_t status,
  output osm_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SEND
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_SEND);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = status.inject ? S_SCAN : S_SEND;
      end
      S_SCAN: begin
        if (status.bit_set) begin
          cmd.emit   = 1'b1;
          state_next = S_SEND;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      S_SEND: begin
        if (out_ready) begin
          if (status.last) begin
            state_next = S_IDLE;
          end else begin
            cmd.advance = 1'b1;
            state_next  = S_SCAN;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/osm_datapath.sv @@
`timescale 1ns / 1ps

module osm_datapath #(
  parameter int NUM_MODS = osm_pkg::NUM_MODS_DEF,
  parameter int OSM_BASE = osm_pkg::OSM_BASE_DEF,
  parameter int MOD_BASE = osm_pkg::MOD_BASE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  osm_pkg::cmd_t                 cmd,
  output osm_pkg::status_t              status,
  // configuration writes
  input  logic                          cfg_we,
  input  logic [osm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [osm_pkg::CFG_DAT_W-1:0] cfg_data,
  // incoming item
  input  logic                          mode,
  input  logic [osm_pkg::KEY_W-1:0]     key_code,
  input  logic                          key_down,
  input  logic                          was_pressed,
  input  logic                          injected,
  // result register
  output logic [osm_pkg::KEY_W-1:0]     out_key,
  output logic                          injected_press,
  output logic                          active,
  output logic                          last
);

  localparam int KW    = osm_pkg::KEY_W;
  localparam int CW    = osm_pkg::CNT_W;
  localparam int IDX_W = (NUM_MODS > 1) ? $clog2(NUM_MODS) : 1;

  localparam logic [KW:0]   MOD_LO = (KW + 1)'(MOD_BASE);
  localparam logic [KW:0]   MOD_HI = (KW + 1)'(MOD_BASE + NUM_MODS);
  localparam logic [KW:0]   OSM_LO = (KW + 1)'(OSM_BASE);
  localparam logic [KW:0]   OSM_HI = (KW + 1)'(OSM_BASE + NUM_MODS);
  localparam logic [KW-1:0] MOD_K  = KW'(MOD_BASE);
  localparam logic [KW-1:0] OSM_K  = KW'(OSM_BASE);

  // Configuration registers.
  logic          enable;
  logic          auto_convert;
  logic [CW-1:0] timeout_ticks;

  // Modifier state.
  logic [NUM_MODS-1:0] oneshot_bits;
  logic [NUM_MODS-1:0] sticky_bits;
  logic [CW-1:0]       tick_count;
  logic [KW-1:0]       previous_key;
  logic                cancel_pending;
  logic                cancel_sticky_too;

  // Captured item.
  logic          it_mode;
  logic [KW-1:0] it_key;
  logic          it_is;
  logic          it_was;
  logic          it_inj;

  // Injection scan.
  logic [NUM_MODS-1:0] inj_mask;
  logic [IDX_W-1:0]    scan_idx;
  logic [NUM_MODS-1:0] mask_clr;

  // Next-state terms.
  logic [NUM_MODS-1:0] oneshot_next;
  logic [NUM_MODS-1:0] sticky_next;
  logic [CW-1:0]       tick_count_next;
  logic [KW-1:0]       previous_key_next;
  logic                cancel_pending_next;
  logic                cancel_sticky_too_next;
  logic [KW-1:0]       res_key;
  logic                inject;
  logic                active_next;

  // Key decode.
  logic                plain_mod;
  logic                convert;
  logic [IDX_W-1:0]    mod_off;
  logic [KW-1:0]       key_c;
  logic                osm;
  logic [IDX_W-1:0]    idx;
  logic [NUM_MODS-1:0] idx_bit;
  logic [KW-1:0]       mod_key;
  logic                on;

  always_comb begin
    plain_mod = ({1'b0, it_key} >= MOD_LO) && ({1'b0, it_key} < MOD_HI);
    convert   = auto_convert && plain_mod && !it_inj;
    mod_off   = IDX_W'(it_key - MOD_K);
    key_c     = convert ? (OSM_K + KW'(mod_off)) : it_key;
    osm       = ({1'b0, key_c} >= OSM_LO) && ({1'b0, key_c} < OSM_HI);
    idx       = IDX_W'(key_c - OSM_K);
    idx_bit   = NUM_MODS'(1) << idx;
    mod_key   = MOD_K + KW'(idx);
    on        = it_is && !it_was;
  end

  always_comb begin
    oneshot_next           = oneshot_bits;
    sticky_next            = sticky_bits;
    tick_count_next        = tick_count;
    previous_key_next      = previous_key;
    cancel_pending_next    = cancel_pending;
    cancel_sticky_too_next = cancel_sticky_too;
    res_key                = '0;
    inject                 = 1'b0;
    if (it_mode == osm_pkg::MODE_TICK) begin
      if (enable && (oneshot_bits != '0)) begin
        tick_count_next = (tick_count != '1) ? tick_count + 1'b1 : tick_count;
        if (tick_count_next > timeout_ticks) begin
          cancel_pending_next    = 1'b1;
          cancel_sticky_too_next = 1'b0;
        end
        if (cancel_pending_next) begin
          // A sticky cancel drops everything; a plain one keeps sticky modifiers.
          oneshot_next           = cancel_sticky_too_next ? '0 : (oneshot_bits & sticky_bits);
          sticky_next            = cancel_sticky_too_next ? '0 : sticky_bits;
          tick_count_next        = '0;
          cancel_pending_next    = 1'b0;
          cancel_sticky_too_next = 1'b0;
        end else begin
          inject = 1'b1;
        end
      end
    end else if (!enable) begin
      res_key = osm ? mod_key : key_c;
    end else begin
      if ((oneshot_bits != '0) && !osm && on && !it_inj) begin
        cancel_pending_next    = 1'b1;
        cancel_sticky_too_next = 1'b0;
      end
      if (!osm) begin
        if (!it_inj && on) begin
          previous_key_next = key_c;
        end
        res_key = key_c;
      end else if (!it_is && !it_was) begin
        res_key = '0;
      end else if (!it_is) begin
        if (tick_count > timeout_ticks) begin
          cancel_pending_next    = 1'b1;
          cancel_sticky_too_next = 1'b0;
        end
      end else if (on && sticky_bits[idx]) begin
        cancel_pending_next    = 1'b1;
        cancel_sticky_too_next = 1'b1;
      end else begin
        if (on && (key_c == previous_key)) begin
          sticky_next = sticky_bits | idx_bit;
        end
        previous_key_next = key_c;
        oneshot_next      = oneshot_bits | idx_bit;
        res_key           = mod_key;
      end
    end
    active_next = (oneshot_next != '0) && !(tick_count_next > timeout_ticks) &&
                  !cancel_pending_next;
  end

  assign mask_clr = inj_mask & ~(NUM_MODS'(1) << scan_idx);

  assign status.inject  = inject;
  assign status.bit_set = inj_mask[scan_idx];
  assign status.last    = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable            <= osm_pkg::ENABLE_RESET;
      auto_convert      <= osm_pkg::AUTO_RESET;
      timeout_ticks     <= osm_pkg::TIMEOUT_RESET;
      oneshot_bits      <= '0;
      sticky_bits       <= '0;
      tick_count        <= '0;
      previous_key      <= '0;
      cancel_pending    <= 1'b0;
      cancel_sticky_too <= 1'b0;
      inj_mask          <= '0;
      scan_idx          <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          osm_pkg::CFG_ENABLE:  enable        <= cfg_data[0];
          osm_pkg::CFG_AUTO:    auto_convert  <= cfg_data[0];
          osm_pkg::CFG_TIMEOUT: timeout_ticks <= cfg_data[CW-1:0];
          default: ;
        endcase
      end
      if (cmd.exec) begin
        oneshot_bits      <= oneshot_next;
        sticky_bits       <= sticky_next;
        tick_count        <= tick_count_next;
        previous_key      <= previous_key_next;
        cancel_pending    <= cancel_pending_next;
        cancel_sticky_too <= cancel_sticky_too_next;
        inj_mask          <= inject ? oneshot_bits : '0;
        scan_idx          <= '0;
      end else if (cmd.emit) begin
        inj_mask <= mask_clr;
      end else if (cmd.advance) begin
        scan_idx <= IDX_W'(scan_idx + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      it_mode <= mode;
      it_key  <= key_code;
      it_is   <= key_down;
      it_was  <= was_pressed;
      it_inj  <= injected;
    end
    if (cmd.exec) begin
      out_key        <= res_key;
      injected_press <= 1'b0;
      active         <= active_next;
      last           <= !inject;
    end else if (cmd.emit) begin
      out_key        <= MOD_K + KW'(scan_idx);
      injected_press <= 1'b1;
      last           <= (mask_clr == '0);
    end
  end

endmodule

@@ rtl/one_shot_sticky_modifiers.sv @@
`timescale 1ns / 1ps
// An accepted item is evaluated, then, for a tick that injects presses, scanned, before
// its result is offered. Items do not overlap: a new one is taken only in idle, after the
// last result of the previous one is accepted. A tick that injects presses walks the
// slots one per cycle up to the last press, pausing on each press until it is accepted.
// Reset (rst, synchronous, active high) clears all modifier state, restores the
// configuration defaults and returns the controller to idle; no clearing pass is needed.

module one_shot_sticky_modifiers #(
  parameter int NUM_MODS = osm_pkg::NUM_MODS_DEF,
  parameter int OSM_BASE = osm_pkg::OSM_BASE_DEF,
  parameter int MOD_BASE = osm_pkg::MOD_BASE_DEF
) (
  input logic       clk,
  input logic       rst,
  osm_in_if.sink    req,
  osm_out_if.source rsp,
  osm_cfg_if.sink   cfg
);

  // The controller sequences each item through capture, evaluation, an optional
  // scan over the injection mask, and delivery. The datapath holds the state,
  // the configuration registers and the result register.
  osm_pkg::cmd_t    cmd;
  osm_pkg::status_t status;

  // Configuration writes are registered directly, so the port never stalls.
  assign cfg.ready = 1'b1;

  osm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  osm_datapath #(
    .NUM_MODS (NUM_MODS),
    .OSM_BASE (OSM_BASE),
    .MOD_BASE (MOD_BASE)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg.valid),
    .cfg_index      (cfg.index),
    .cfg_data       (cfg.data),
    .mode           (req.mode),
    .key_code       (req.key_code),
    .key_down       (req.key_down),
    .was_pressed    (req.was_pressed),
    .injected       (req.injected),
    .out_key        (rsp.out_key),
    .injected_press (rsp.injected_press),
    .active         (rsp.active),
    .last           (rsp.last)
  );

`ifndef SYNTHESIS
  // Only one item is in flight: no new item is taken while a result is offered.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !req.ready)
    else $error("input ready while a result is pending");

  // An accepted item spends its next cycle in evaluation, never on the output.
  a_eval_gap: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !rsp.valid)
    else $error("result offered directly after accept");

  // Injected presses only come from an active, non-cancelled state.
  a_inject_active: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.injected_press) |-> rsp.active)
    else $error("injected press while inactive");

  // Injected presses are always plain modifier codes.
  a_inject_range: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.injected_press) |->
      (rsp.out_key >= osm_pkg::KEY_W'(MOD_BASE)) &&
      (rsp.out_key < osm_pkg::KEY_W'(MOD_BASE + NUM_MODS)))
    else $error("injected press outside modifier range");
`endif

endmodule

@@ tb/osm_key_report_checker.sv @@
`timescale 1ns / 1ps

module osm_key_report_checker
  import osm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  osm_in_if    req,
  osm_out_if   rsp,
  osm_cfg_if   cfg,
  output int   mismatches,
  output int   reports_due
);

  localparam int NMOD   = NUM_MODS_DEF;
  localparam int OSM_LO = OSM_BASE_DEF;
  localparam int MOD_LO = MOD_BASE_DEF;

  typedef struct packed {
    logic [KEY_W-1:0] out_key;
    logic             injected_press;
    logic             active;
    logic             last;
  } key_report_t;

  // Shadow copy of the registers and the modifier state.
  logic             enable_q;
  logic             auto_q;
  logic [CNT_W-1:0] timeout_q;
  logic [NMOD-1:0]  oneshot_q;
  logic [NMOD-1:0]  sticky_q;
  logic [CNT_W-1:0] ticks_q;
  logic [KEY_W-1:0] prev_key_q;
  logic             cancel_q;
  logic             cancel_sticky_q;

  key_report_t      key_reports_due[$];
  key_report_t      due;
  logic [KEY_W-1:0] tick_presses[NMOD];

  function automatic logic is_oneshot_code(input logic [KEY_W-1:0] k);
    return int'(k) >= OSM_LO && int'(k) < OSM_LO + NMOD;
  endfunction

  function automatic logic is_plain_mod(input logic [KEY_W-1:0] k);
    return int'(k) >= MOD_LO && int'(k) < MOD_LO + NMOD;
  endfunction

  task automatic ask_cancel(input logic with_sticky);
    cancel_q        = 1'b1;
    cancel_sticky_q = with_sticky;
  endtask

  task automatic clear_state();
    enable_q        = ENABLE_RESET;
    auto_q          = AUTO_RESET;
    timeout_q       = TIMEOUT_RESET;
    oneshot_q       = '0;
    sticky_q        = '0;
    ticks_q         = '0;
    prev_key_q      = '0;
    cancel_q        = 1'b0;
    cancel_sticky_q = 1'b0;
  endtask

  task automatic apply_key_event(input logic [KEY_W-1:0] code, input logic down,
                                 input logic was_down, input logic synth,
                                 output logic [KEY_W-1:0] res);
    logic [KEY_W-1:0] k;
    logic             fresh;
    int               idx;
    k     = code;
    fresh = down && !was_down;
    if (auto_q && is_plain_mod(k) && !synth) k = KEY_W'(int'(k) - MOD_LO + OSM_LO);
    if (!enable_q) begin
      res = is_oneshot_code(k) ? KEY_W'(int'(k) - OSM_LO + MOD_LO) : k;
    end else begin
      // A fresh physical press of any other key asks for a plain cancel of the one-shot state.
      if (oneshot_q != '0 && !is_oneshot_code(k) && fresh && !synth) ask_cancel(1'b0);
      if (!is_oneshot_code(k)) begin
        if (!synth && fresh) prev_key_q = k;
        res = k;
      end else if (!down && !was_down) begin
        res = '0;
      end else if (!down) begin
        if (ticks_q > timeout_q) ask_cancel(1'b0);
        res = '0;
      end else begin
        idx = int'(k) - OSM_LO;
        if (fresh && sticky_q[idx]) begin
          ask_cancel(1'b1);
          res = '0;
        end else begin
          if (fresh && k == prev_key_q) sticky_q[idx] = 1'b1;
          prev_key_q     = k;
          oneshot_q[idx] = 1'b1;
          res            = KEY_W'(MOD_LO + idx);
        end
      end
    end
  endtask

  task automatic run_scan_tick(output int n);
    int i;
    n = 0;
    if (enable_q && oneshot_q != '0) begin
      if (ticks_q != '1) ticks_q = ticks_q + 1'b1;
      if (ticks_q > timeout_q) ask_cancel(1'b0);
      for (i = 0; i < NMOD; i++) begin
        if (cancel_q) begin
          if (sticky_q[i]) begin
            if (cancel_sticky_q) begin
              sticky_q[i]  = 1'b0;
              oneshot_q[i] = 1'b0;
            end
          end else begin
            oneshot_q[i] = 1'b0;
          end
        end else if (oneshot_q[i]) begin
          tick_presses[n] = KEY_W'(MOD_LO + i);
          n++;
        end
      end
      if (cancel_q) begin
        ticks_q         = '0;
        cancel_q        = 1'b0;
        cancel_sticky_q = 1'b0;
      end
    end
  endtask

  task automatic apply_item(input logic kind, input logic [KEY_W-1:0] code,
                            input logic down, input logic was_down, input logic synth);
    int               n;
    int               i;
    logic             live;
    logic [KEY_W-1:0] k;
    key_report_t      r;
    n = 0;
    k = '0;
    if (kind == MODE_TICK) run_scan_tick(n);
    else apply_key_event(code, down, was_down, synth, k);
    live = oneshot_q != '0 && !(ticks_q > timeout_q) && !cancel_q;
    if (n == 0) begin
      r = '{out_key: k, injected_press: 1'b0, active: live, last: 1'b1};
      key_reports_due.push_back(r);
    end else begin
      for (i = 0; i < n; i++) begin
        r = '{out_key: tick_presses[i], injected_press: 1'b1, active: live,
              last: (i == n - 1)};
        key_reports_due.push_back(r);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_state();
      key_reports_due.delete();
      mismatches = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_ENABLE:  enable_q  = cfg.data[0];
          CFG_AUTO:    auto_q    = cfg.data[0];
          CFG_TIMEOUT: timeout_q = cfg.data;
          default: ;
        endcase
      end
      if (req.valid && req.ready)
        apply_item(req.mode, req.key_code, req.key_down, req.was_pressed, req.injected);
      if (rsp.valid && rsp.ready) begin
        if (key_reports_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: key %h inj %b active %b last %b",
                     rsp.out_key, rsp.injected_press, rsp.active, rsp.last);
        end else begin
          due = key_reports_due.pop_front();
          if (rsp.out_key !== due.out_key || rsp.injected_press !== due.injected_press ||
              rsp.active !== due.active || rsp.last !== due.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch (exp/got): key %h/%h inj %b/%b active %b/%b last %b/%b",
                       due.out_key, rsp.out_key, due.injected_press, rsp.injected_press,
                       due.active, rsp.active, due.last, rsp.last);
          end
        end
      end
    end
    reports_due <= key_reports_due.size();
  end

endmodule

@@ tb/tb_one_shot_sticky_modifiers.sv @@
`timescale 1ns / 1ps

module tb_one_shot_sticky_modifiers;
  import osm_pkg::*;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int ITEMS_PER_PHASE = 54;
  localparam int SWEEP_TICKS = 16;
  localparam logic [KEY_W-1:0] OSM_KEY0 = KEY_W'(OSM_BASE_DEF);
  localparam logic [KEY_W-1:0] MOD_KEY0 = KEY_W'(MOD_BASE_DEF);

  logic clk;
  logic rst;
  int   mismatches;
  int   reports_due;
  int   cycles = 0;

  // Knobs shared by the stimulus and the result sink.
  logic                sink_hold_ready;
  logic                sender_no_gaps;
  int                  burst_left;
  int                  fav_slot;
  logic [NUM_MODS_DEF-1:0] key_held;

  osm_in_if  req();
  osm_out_if rsp();
  osm_cfg_if cfg();

  one_shot_sticky_modifiers i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  // The checker watches all three channels and keeps its own copy of the state.
  osm_key_report_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .cfg         (cfg),
    .mismatches  (mismatches),
    .reports_due (reports_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // The result sink switches between stall styles at random: always ready,
  // mostly ready, mostly stalled, or a regular train of stalls. The timer sweep
  // overrides it so that the run stays short.
  initial begin
    int style_left;
    int sink_style;
    rsp.ready <= 1'b0;
    style_left = 0;
    sink_style = 0;
    forever begin
      @(posedge clk);
      if (style_left == 0) begin
        sink_style = $urandom_range(0, 3);
        style_left = $urandom_range(30, 300);
      end
      style_left--;
      if (sink_hold_ready) begin
        rsp.ready <= 1'b1;
      end else begin
        case (sink_style)
          0: rsp.ready <= 1'b1;
          1: rsp.ready <= ($urandom_range(0, 3) != 0);
          2: rsp.ready <= ($urandom_range(0, 3) == 0);
          default: rsp.ready <= ((style_left % 7) < 3);
        endcase
      end
    end
  end

  // Offers one item and returns at the edge where it is taken. Valid stays high
  // when the burst goes on, so back-to-back items never drop it for a step.
  task automatic send_item(input logic kind, input logic [KEY_W-1:0] code,
                           input logic down, input logic was_down, input logic synth);
    req.valid       <= 1'b1;
    req.mode        <= kind;
    req.key_code    <= code;
    req.key_down    <= down;
    req.was_pressed <= was_down;
    req.injected    <= synth;
    do @(posedge clk); while (!req.ready);
    if (burst_left > 0) begin
      burst_left--;
    end else if (!sender_no_gaps) begin
      req.valid <= 1'b0;
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(5, 20)) @(posedge clk);
      else repeat ($urandom_range(1, 4)) @(posedge clk);
      burst_left = $urandom_range(0, 11);
    end
  endtask

  // A scan tick ignores the key fields, so they carry noise.
  task automatic send_tick();
    send_item(MODE_TICK, KEY_W'($urandom), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // Drops valid and waits until every predicted result has come back, then lets
  // the controller return to idle before a register write.
  task automatic settle();
    req.valid <= 1'b0;
    @(posedge clk);
    while (reports_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Random traffic is shaped like real typing: one-shot keys are tapped as press
  // then release, the same slot is reused often so double taps make keys sticky,
  // and ordinary keys, plain modifiers, ticks and codes just outside the modifier
  // ranges are mixed in.
  task automatic send_random_item();
    int               pick;
    int               slot;
    logic [KEY_W-1:0] code;
    logic             down;
    logic             was_down;
    logic             synth;
    pick     = $urandom_range(0, 99);
    code     = KEY_W'($urandom);
    down     = 1'($urandom_range(0, 1));
    was_down = 1'($urandom_range(0, 1));
    synth    = ($urandom_range(0, 6) == 0);
    slot     = ($urandom_range(0, 2) == 0) ? $urandom_range(0, NUM_MODS_DEF - 1) : fav_slot;
    fav_slot = slot;
    if (pick < 30) begin
      send_tick();
    end else if (pick < 60) begin
      if (key_held[slot]) begin
        down     = ($urandom_range(0, 4) == 0);
        was_down = 1'b1;
      end else begin
        down     = ($urandom_range(0, 9) != 0);
        was_down = ($urandom_range(0, 9) == 0);
      end
      key_held[slot] = down;
      send_item(MODE_KEY, OSM_KEY0 + KEY_W'(slot), down, was_down, synth);
    end else if (pick < 70) begin
      down     = ($urandom_range(0, 3) != 0);
      was_down = !down || ($urandom_range(0, 4) == 0);
      synth    = ($urandom_range(0, 2) == 0);
      send_item(MODE_KEY, MOD_KEY0 + KEY_W'(slot), down, was_down, synth);
    end else if (pick < 88) begin
      down     = ($urandom_range(0, 9) < 7);
      was_down = !down;
      if ($urandom_range(0, 4) == 0) was_down = 1'($urandom_range(0, 1));
      send_item(MODE_KEY, code, down, was_down, synth);
    end else begin
      case ($urandom_range(0, 5))
        0: code = OSM_KEY0 - 1'b1;
        1: code = OSM_KEY0 + KEY_W'(NUM_MODS_DEF);
        2: code = MOD_KEY0 - 1'b1;
        3: code = MOD_KEY0 + KEY_W'(NUM_MODS_DEF);
        4: code = '0;
        default: code = '1;
      endcase
      send_item(MODE_KEY, code, down, was_down, synth);
    end
  endtask

  initial begin
    int p;
    int i;
    rst             <= 1'b1;
    req.valid       <= 1'b0;
    req.mode        <= MODE_KEY;
    req.key_code    <= '0;
    req.key_down    <= 1'b0;
    req.was_pressed <= 1'b0;
    req.injected    <= 1'b0;
    cfg.valid       <= 1'b0;
    cfg.index       <= CFG_ENABLE;
    cfg.data        <= '0;
    sink_hold_ready = 1'b0;
    sender_no_gaps  = 1'b0;
    burst_left      = 0;
    fav_slot        = 0;
    key_held        = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed pass on the reset configuration. A tick with nothing held comes
    // back as a single empty result.
    send_tick();
    // Tap slot 0: it becomes its plain modifier and is injected on the next tick.
    send_item(MODE_KEY, OSM_KEY0, 1'b1, 1'b0, 1'b0);
    send_tick();
    send_item(MODE_KEY, OSM_KEY0, 1'b0, 1'b1, 1'b0);
    // Second tap in a row makes slot 0 sticky.
    send_item(MODE_KEY, OSM_KEY0, 1'b1, 1'b0, 1'b0);
    send_tick();
    // Tapping a sticky key asks for a cancel that takes the sticky keys too, but a
    // later press of key zero replaces it with a plain cancel, which spares slot 0.
    send_item(MODE_KEY, OSM_KEY0, 1'b1, 1'b0, 1'b0);
    send_item(MODE_KEY, '0, 1'b1, 1'b0, 1'b0);
    send_tick();
    // A held report of slot 7 sets it without the tap logic; a one-shot event with
    // neither pressed bit changes nothing; an injected press does not cancel.
    send_item(MODE_KEY, OSM_KEY0 + KEY_W'(7), 1'b1, 1'b1, 1'b0);
    send_item(MODE_KEY, OSM_KEY0 + KEY_W'(3), 1'b0, 1'b0, 1'b0);
    send_item(MODE_KEY, '1, 1'b1, 1'b0, 1'b1);
    send_tick();
    // A sticky cancel clears the sticky slot and every one-shot bit.
    send_item(MODE_KEY, OSM_KEY0, 1'b1, 1'b0, 1'b0);
    send_tick();
    // All slots held at once give a tick with the full run of injected presses.
    for (i = 0; i < NUM_MODS_DEF; i++)
      send_item(MODE_KEY, OSM_KEY0 + KEY_W'(i), 1'b1, 1'b1, 1'b0);
    send_tick();
    send_item(MODE_KEY, 16'h8000, 1'b1, 1'b0, 1'b0);
    send_tick();
    settle();

    // Timer sweep: with the largest timeout the counter climbs one step per tick
    // without timing out. Lowering the timeout below the count then makes the
    // state time out, so the release that follows asks for a cancel.
    write_reg(CFG_TIMEOUT, 16'hFFFF);
    sink_hold_ready = 1'b1;
    sender_no_gaps  = 1'b1;
    send_item(MODE_KEY, OSM_KEY0 + KEY_W'(5), 1'b1, 1'b1, 1'b0);
    for (i = 0; i < SWEEP_TICKS; i++)
      send_item(MODE_TICK, '0, 1'b0, 1'b0, 1'b0);
    settle();
    write_reg(CFG_TIMEOUT, CFG_DAT_W'(SWEEP_TICKS - 1));
    send_item(MODE_KEY, OSM_KEY0 + KEY_W'(5), 1'b0, 1'b1, 1'b0);
    send_tick();
    sink_hold_ready = 1'b0;
    sender_no_gaps  = 1'b0;
    settle();

    // Auto conversion with a zero timeout: physical plain modifiers turn into
    // one-shot keys, injected ones pass through, and the first tick times out.
    write_reg(CFG_ENABLE, 16'h0001);
    write_reg(CFG_AUTO, 16'h0001);
    write_reg(CFG_TIMEOUT, 16'h0000);
    send_item(MODE_KEY, MOD_KEY0 + KEY_W'(2), 1'b1, 1'b0, 1'b0);
    send_item(MODE_KEY, MOD_KEY0 + KEY_W'(2), 1'b1, 1'b0, 1'b1);
    send_item(MODE_KEY, MOD_KEY0 + KEY_W'(7), 1'b0, 1'b1, 1'b0);
    send_tick();
    send_item(MODE_KEY, MOD_KEY0 + KEY_W'(6), 1'b1, 1'b0, 1'b0);
    settle();

    // Disabled: one-shot codes only map to plain modifiers, ticks are empty and
    // the held slot survives for the next enabled phase.
    write_reg(CFG_ENABLE, 16'h0000);
    send_item(MODE_KEY, OSM_KEY0 + KEY_W'(4), 1'b1, 1'b0, 1'b0);
    send_item(MODE_KEY, MOD_KEY0 + KEY_W'(1), 1'b1, 1'b0, 1'b0);
    send_item(MODE_KEY, 16'h1234, 1'b1, 1'b0, 1'b0);
    send_tick();
    settle();

    // Random phases, each on its own register setting. Short timeouts make
    // timeouts common; one phase runs without sender gaps.
    for (p = 0; p < 6; p++) begin
      case (p)
        0: begin
          write_reg(CFG_ENABLE, 16'h0001);
          write_reg(CFG_AUTO, 16'h0000);
          write_reg(CFG_TIMEOUT, 16'd5);
        end
        1: begin
          write_reg(CFG_ENABLE, 16'h0001);
          write_reg(CFG_AUTO, 16'h0001);
          write_reg(CFG_TIMEOUT, 16'd12);
        end
        2: begin
          write_reg(CFG_ENABLE, 16'h0000);
          write_reg(CFG_AUTO, 16'h0001);
          write_reg(CFG_TIMEOUT, CFG_DAT_W'($urandom_range(0, 65535)));
        end
        3: begin
          write_reg(CFG_ENABLE, 16'hFFFF);
          write_reg(CFG_AUTO, 16'h0000);
          write_reg(CFG_TIMEOUT, 16'd2);
        end
        4: begin
          write_reg(CFG_ENABLE, 16'h0001);
          write_reg(CFG_AUTO, 16'hFFFF);
          write_reg(CFG_TIMEOUT, CFG_DAT_W'($urandom_range(0, 3)));
          sender_no_gaps = 1'b1;
        end
        default: begin
          write_reg(CFG_ENABLE, 16'h0001);
          write_reg(CFG_AUTO, 16'h0000);
          write_reg(CFG_TIMEOUT, CFG_DAT_W'($urandom_range(0, 65535)));
        end
      endcase
      for (i = 0; i < ITEMS_PER_PHASE; i++) send_random_item();
      sender_no_gaps = 1'b0;
      settle();
    end

    if (mismatches == 0 && reports_due == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
